[src/wavelet_range_kth_count_sum_unit_assert.svh]
// Assertion macros for the wavelet range engine.
// Users must have clk and arst_n in scope.
`ifndef WAVELET_RANGE_KTH_COUNT_SUM_UNIT_ASSERT_SVH
`define WAVELET_RANGE_KTH_COUNT_SUM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WRKS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WRKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/wrks_pkg.sv]
// Shared types and constants for the wavelet range engine.
// No dependencies; used by the top level, wrks_step and the testbench.
package wrks_pkg;

	localparam int unsigned VALUE_BITS = 16;
	localparam int unsigned MAX_LENGTH = 1024;
	localparam int unsigned LVL_W      = $clog2(VALUE_BITS);
	localparam int unsigned ADDR_W     = $clog2(MAX_LENGTH);
	localparam int unsigned IDX_W      = ADDR_W + 1;
	localparam int unsigned LEV_AW     = LVL_W + IDX_W;
	localparam int unsigned OP_W       = 17;
	localparam int unsigned THR_W      = OP_W + 1;
	localparam int unsigned ANS_W      = 16;
	localparam int unsigned SUM_W      = 26;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned IN_W       = 48;
	localparam int unsigned OUT_W      = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 3'd0,
		CMD_APPEND   = 3'd1,
		CMD_BUILD    = 3'd2,
		CMD_KTH      = 3'd3,
		CMD_LESS     = 3'd4,
		CMD_AT_MOST  = 3'd5,
		CMD_FREQ     = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_RANGE = 2'd1,
		STAT_BAD_RANK  = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DONE,
		S_B_CNT,
		S_B_PART,
		S_Q_CHK,
		S_Q_RD,
		S_Q_EX,
		S_Q_FULL_RD,
		S_Q_FULL_EX,
		S_Q_END
	} state_t;

	typedef enum logic [1:0] {
		SRC_RAW,
		SRC_A,
		SRC_B
	} src_t;

	// Operands of one descent step
	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] ol;
		logic [IDX_W-1:0] oh;
		logic [IDX_W-1:0] split;
		logic             kth_mode;
		logic [OP_W-1:0]  rank;
		logic             thr_bit;
	} step_in_t;

	// Result of one descent step
	typedef struct packed {
		logic             go_one;
		logic [IDX_W-1:0] zeros;
		logic [IDX_W-1:0] lo_n;
		logic [IDX_W-1:0] hi_n;
	} step_out_t;

endpackage

[src/wavelet_range_kth_count_sum_unit.sv]
// Top level of the wavelet range engine: sequencer, build passes, queries.
// Depends on wrks_pkg, wrks_ram, wrks_step and the assertion header.
//
// channel  | dir | handshake          | contents
// s_axis   | in  | s_tvalid/s_tready  | cmd, range_start, range_end, operand
// m_axis   | out | m_tvalid/m_tready  | status, answer, total
//
// Clear, append and rejected queries go straight to the result. Queries step
// through every level of the shared descent step; a zero threshold skips the
// descent and a threshold above every value reads the prefix sums. Frequency
// runs two passes. Build: a count pass and a partition pass per level over 16
// levels, each sweeping the stored values. No item is taken while one runs.
// Reset clears length and built flag; memories keep contents.
// A held result stalls the sequencer in its final state only.
`include "wavelet_range_kth_count_sum_unit_assert.svh"

module wavelet_range_kth_count_sum_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// cmd[2:0], range_start[13:3], range_end[24:14], operand[41:25], zero pad
	input  logic [wrks_pkg::IN_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[1:0], answer[17:2], total[43:18], zero pad
	output logic [wrks_pkg::OUT_W-1:0] m_tdata
);
	import wrks_pkg::*;

	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(VALUE_BITS - 1);
	localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(MAX_LENGTH);

	state_t state_q, state_d;

	cmd_t             in_cmd, cmd_q;
	logic [IDX_W-1:0] in_s, in_e, span;
	logic [OP_W-1:0]  in_op, op_q;
	logic             accept, bad_range, out_free;
	status_t          in_status;

	logic [IDX_W-1:0] len_q, s_q, e_q, lo_q, hi_q, cnt_q, first_cnt_q;
	logic             built_q, phase_q, m_tvalid_q;
	logic [LVL_W-1:0] lvl_q;
	logic [OP_W-1:0]  rank_q;
	logic [ANS_W-1:0] ans_q;
	logic [SUM_W-1:0] sum_q;
	logic [THR_W-1:0] thr_q;
	logic [VALUE_BITS-1:0] thr_lo;
	status_t          res_status_q;
	logic [ANS_W-1:0] res_answer_q;
	logic [SUM_W-1:0] res_total_q;
	logic [OUT_W-1:0] m_tdata_q;

	// Build pass registers
	logic [IDX_W-1:0] ctr_q, ones_q, zpos_q, opos_q, ones_n;
	logic [SUM_W-1:0] zs_q, vs_q, zs_n, vs_n;
	src_t             src_q, dst;
	logic [IDX_W-1:0] split_q [VALUE_BITS];

	// Memory ports
	logic                  raw_we, sa_we, sb_we, lev_we, vps_we;
	logic [ADDR_W-1:0]     raw_waddr, part_waddr;
	logic [VALUE_BITS-1:0] raw_rd, sa_rd, sb_rd, src_rd;
	logic [LEV_AW-1:0]     lev_waddr;
	logic [IDX_W-1:0]      lop_wdata, lop_a, lop_b;
	logic [SUM_W-1:0]      lzs_wdata, lzs_a, lzs_b, vps_wdata, vps_a, vps_b;
	logic                  src_bit, first_slot, last_slot;

	step_in_t  si;
	step_out_t so;

	assign in_cmd    = cmd_t'(s_tdata[2:0]);
	assign in_s      = s_tdata[13:3];
	assign in_e      = s_tdata[24:14];
	assign in_op     = s_tdata[41:25];
	assign accept    = s_tvalid && s_tready;
	assign bad_range = (in_s > in_e) || (in_e > len_q);
	assign span      = in_e - in_s;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign thr_lo    = thr_q[VALUE_BITS-1:0];

	// Classify the incoming transaction
	always_comb begin
		in_status = STAT_OK;
		case (in_cmd)
			CMD_APPEND: begin
				if (len_q >= LEN_MAX) in_status = STAT_FULL;
			end
			CMD_KTH, CMD_LESS, CMD_AT_MOST, CMD_FREQ: begin
				if (!built_q) in_status = STAT_FULL;
				else if (bad_range) in_status = STAT_BAD_RANGE;
				else if (in_cmd == CMD_KTH && in_op >= OP_W'(span))
					in_status = STAT_BAD_RANK;
			end
			default: in_status = STAT_OK;
		endcase
	end

	// Select build source and destination scratch buffers
	always_comb begin
		case (src_q)
			SRC_A:   begin src_rd = sa_rd;  dst = SRC_B; end
			SRC_B:   begin src_rd = sb_rd;  dst = SRC_A; end
			default: begin src_rd = raw_rd; dst = SRC_A; end
		endcase
	end

	assign src_bit    = src_rd[lvl_q];
	assign first_slot = (ctr_q == '0);
	assign last_slot  = (ctr_q == len_q);
	assign ones_n     = first_slot ? '0 : ones_q + IDX_W'(src_bit);
	assign zs_n       = first_slot ? '0 : zs_q + (src_bit ? '0 : SUM_W'(src_rd));
	assign vs_n       = first_slot ? '0 : vs_q + SUM_W'(src_rd);

	// Shared descent step
	assign si.lo       = lo_q;
	assign si.hi       = hi_q;
	assign si.ol       = lop_a;
	assign si.oh       = lop_b;
	assign si.split    = split_q[lvl_q];
	assign si.kth_mode = (cmd_q == CMD_KTH);
	assign si.rank     = rank_q;
	assign si.thr_bit  = thr_lo[lvl_q];

	wrks_step u_step (
		.si (si),
		.so (so)
	);

	wrks_ram #(.AW(ADDR_W), .W(VALUE_BITS)) u_raw (
		.clk(clk), .we(raw_we), .waddr(raw_waddr), .wdata(in_op[VALUE_BITS-1:0]),
		.raddr_a(ctr_q[ADDR_W-1:0]), .rdata_a(raw_rd),
		.raddr_b(ctr_q[ADDR_W-1:0]), .rdata_b()
	);

	wrks_ram #(.AW(ADDR_W), .W(VALUE_BITS)) u_sa (
		.clk(clk), .we(sa_we), .waddr(part_waddr), .wdata(src_rd),
		.raddr_a(ctr_q[ADDR_W-1:0]), .rdata_a(sa_rd),
		.raddr_b(ctr_q[ADDR_W-1:0]), .rdata_b()
	);

	wrks_ram #(.AW(ADDR_W), .W(VALUE_BITS)) u_sb (
		.clk(clk), .we(sb_we), .waddr(part_waddr), .wdata(src_rd),
		.raddr_a(ctr_q[ADDR_W-1:0]), .rdata_a(sb_rd),
		.raddr_b(ctr_q[ADDR_W-1:0]), .rdata_b()
	);

	wrks_ram #(.AW(LEV_AW), .W(IDX_W)) u_lop (
		.clk(clk), .we(lev_we), .waddr(lev_waddr), .wdata(lop_wdata),
		.raddr_a({lvl_q, lo_q}), .rdata_a(lop_a),
		.raddr_b({lvl_q, hi_q}), .rdata_b(lop_b)
	);

	wrks_ram #(.AW(LEV_AW), .W(SUM_W)) u_lzs (
		.clk(clk), .we(lev_we), .waddr(lev_waddr), .wdata(lzs_wdata),
		.raddr_a({lvl_q, lo_q}), .rdata_a(lzs_a),
		.raddr_b({lvl_q, hi_q}), .rdata_b(lzs_b)
	);

	wrks_ram #(.AW(IDX_W), .W(SUM_W)) u_vps (
		.clk(clk), .we(vps_we), .waddr(ctr_q), .wdata(vps_wdata),
		.raddr_a(lo_q), .rdata_a(vps_a),
		.raddr_b(hi_q), .rdata_b(vps_b)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (in_cmd)
						CMD_BUILD: state_d = S_B_CNT;
						CMD_KTH, CMD_LESS, CMD_AT_MOST, CMD_FREQ: begin
							if (!built_q || bad_range
									|| (in_cmd == CMD_KTH && in_op >= OP_W'(span))
									|| (in_cmd == CMD_FREQ && in_op[VALUE_BITS])) begin
								state_d = S_DONE;
							end else begin
								state_d = S_Q_CHK;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_B_CNT: begin
				if (last_slot) state_d = S_B_PART;
			end
			S_B_PART: begin
				if (last_slot) state_d = (lvl_q == '0) ? S_DONE : S_B_CNT;
			end
			S_Q_CHK: begin
				if (cmd_q == CMD_KTH) state_d = S_Q_RD;
				else if (thr_q == '0) state_d = S_Q_END;
				else if (|thr_q[THR_W-1:VALUE_BITS]) state_d = S_Q_FULL_RD;
				else state_d = S_Q_RD;
			end
			S_Q_RD:      state_d = S_Q_EX;
			S_Q_EX:      state_d = (lvl_q == '0) ? S_Q_END : S_Q_RD;
			S_Q_FULL_RD: state_d = S_Q_FULL_EX;
			S_Q_FULL_EX: state_d = S_Q_END;
			S_Q_END: begin
				state_d = (cmd_q == CMD_FREQ && !phase_q) ? S_Q_CHK : S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory write controls
	always_comb begin
		s_tready   = (state_q == S_IDLE);
		raw_we     = accept && (in_cmd == CMD_APPEND) && (len_q < LEN_MAX);
		raw_waddr  = len_q[ADDR_W-1:0];
		lev_we     = (state_q == S_B_CNT);
		lev_waddr  = {lvl_q, ctr_q};
		lop_wdata  = ones_n;
		lzs_wdata  = zs_n;
		vps_we     = (state_q == S_B_CNT) && (lvl_q == LVL_MAX);
		vps_wdata  = vs_n;
		part_waddr = src_bit ? opos_q[ADDR_W-1:0] : zpos_q[ADDR_W-1:0];
		sa_we      = (state_q == S_B_PART) && !first_slot && (dst == SRC_A);
		sb_we      = (state_q == S_B_PART) && !first_slot && (dst == SRC_B);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			built_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_cmd == CMD_CLEAR) begin
				len_q   <= '0;
				built_q <= 1'b0;
			end
			if (raw_we) begin
				len_q   <= len_q + 1'b1;
				built_q <= 1'b0;
			end
			if (state_q == S_B_PART && last_slot && lvl_q == '0) begin
				built_q <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q        <= in_cmd;
				op_q         <= in_op;
				s_q          <= in_s;
				e_q          <= in_e;
				lo_q         <= in_s;
				hi_q         <= in_e;
				lvl_q        <= LVL_MAX;
				rank_q       <= in_op;
				ans_q        <= '0;
				cnt_q        <= '0;
				sum_q        <= '0;
				phase_q      <= 1'b0;
				thr_q        <= (in_cmd == CMD_LESS) ? THR_W'(in_op) : THR_W'(in_op) + 1'b1;
				ctr_q        <= '0;
				src_q        <= SRC_RAW;
				res_answer_q <= '0;
				res_total_q  <= '0;
				res_status_q <= in_status;
			end
			S_B_CNT: begin
				ones_q <= ones_n;
				zs_q   <= zs_n;
				vs_q   <= vs_n;
				if (last_slot) begin
					split_q[lvl_q] <= len_q - ones_n;
					ctr_q          <= '0;
				end else begin
					ctr_q <= ctr_q + 1'b1;
				end
			end
			S_B_PART: begin
				if (first_slot) begin
					zpos_q <= '0;
					opos_q <= split_q[lvl_q];
				end else if (src_bit) begin
					opos_q <= opos_q + 1'b1;
				end else begin
					zpos_q <= zpos_q + 1'b1;
				end
				if (last_slot) begin
					ctr_q <= '0;
					src_q <= dst;
					if (lvl_q != '0) lvl_q <= lvl_q - 1'b1;
				end else begin
					ctr_q <= ctr_q + 1'b1;
				end
			end
			S_Q_EX: begin
				lo_q <= so.lo_n;
				hi_q <= so.hi_n;
				if (so.go_one) begin
					if (cmd_q == CMD_KTH) begin
						ans_q[lvl_q] <= 1'b1;
						rank_q       <= rank_q - OP_W'(so.zeros);
					end else begin
						cnt_q <= cnt_q + so.zeros;
						sum_q <= sum_q + (lzs_b - lzs_a);
					end
				end
				if (lvl_q != '0) lvl_q <= lvl_q - 1'b1;
			end
			S_Q_FULL_EX: begin
				cnt_q <= hi_q - lo_q;
				sum_q <= vps_b - vps_a;
			end
			S_Q_END: begin
				case (cmd_q)
					CMD_KTH: res_answer_q <= ans_q;
					CMD_LESS, CMD_AT_MOST: begin
						res_answer_q <= ANS_W'(cnt_q);
						res_total_q  <= sum_q;
					end
					CMD_FREQ: begin
						if (!phase_q) begin
							first_cnt_q <= cnt_q;
							thr_q       <= THR_W'(op_q);
							phase_q     <= 1'b1;
							lo_q        <= s_q;
							hi_q        <= e_q;
							lvl_q       <= LVL_MAX;
							cnt_q       <= '0;
							sum_q       <= '0;
						end else begin
							res_answer_q <= ANS_W'(first_cnt_q - cnt_q);
						end
					end
					default: ;
				endcase
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= OUT_W'({res_total_q, res_answer_q, res_status_q});
				end
			end
			default: ;
		endcase
	end

	`WRKS_ASSERT_NEXT(a_len_step, raw_we, len_q == $past(len_q) + 1'b1, "append lost length")
	`WRKS_ASSERT_SAME(a_len_bound, 1'b1, len_q <= LEN_MAX, "length past capacity")
	`WRKS_ASSERT_NEXT(a_q_last, state_q == S_Q_EX && lvl_q == '0, state_q == S_Q_END, "descent overran")
	`WRKS_ASSERT_NEXT(a_out_wait, state_q == S_DONE && m_tvalid && !m_tready, state_q == S_DONE, "result overwrote held output")

endmodule

[src/wrks_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module wrks_ram #(
	parameter int unsigned AW = 10,
	parameter int unsigned W  = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr_a,
	output logic [W-1:0]  rdata_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_b
);

	logic [W-1:0] mem [2**AW];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[src/wrks_step.sv]
// One level of wavelet descent: zero count, branch choice, new bounds.
// Depends on wrks_pkg.
module wrks_step (
	input  wrks_pkg::step_in_t  si,
	output wrks_pkg::step_out_t so
);
	import wrks_pkg::*;

	logic [IDX_W-1:0] zeros;

	// Count zeros in range, pick branch, remap bounds
	always_comb begin
		zeros     = (si.hi - si.lo) - (si.oh - si.ol);
		so.zeros  = zeros;
		so.go_one = si.kth_mode ? (si.rank >= OP_W'(zeros)) : si.thr_bit;
		if (so.go_one) begin
			so.lo_n = si.split + si.ol;
			so.hi_n = si.split + si.oh;
		end else begin
			so.lo_n = si.lo - si.ol;
			so.hi_n = si.hi - si.oh;
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for wavelet_range_kth_count_sum_unit: directed table then random
// sequences of clear/append/build/query sessions, checked against a behavioral predictor.
// Depends on wrks_pkg and the RTL in src.

module testbench;
	import wrks_pkg::*;

	localparam logic [2:0] CMD_RSVD = 3'd7;
	localparam int WATCHDOG_LIMIT = 150000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] answer;
		logic [25:0] total;
	} result_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [10:0] rs;
		logic [10:0] re;
		logic [16:0] op;
		bit          typed;
		result_t     res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	// predictor state
	logic [15:0] seq_vals [MAX_LENGTH];
	int          seq_len = 0;
	bit          seq_built = 0;

	result_t     pending_results[$];
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;
	bit          hold_done = 0;

	wavelet_range_kth_count_sum_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// count and sum of range values strictly below thr
	function automatic void count_below(input int s, input int e, input int thr,
			output int cnt, output longint acc);
		cnt = 0;
		acc = 0;
		for (int i = s; i < e; i++) begin
			if (int'(seq_vals[i]) < thr) begin
				cnt++;
				acc += seq_vals[i];
			end
		end
	endfunction

	function automatic result_t predict_result(input logic [2:0] c, input logic [10:0] rs,
			input logic [10:0] re, input logic [16:0] op);
		result_t r;
		int      cnt, cnt2;
		longint  acc, acc2;
		int      sorted[$];
		r = '0;
		case (c)
			CMD_CLEAR: begin
				seq_len = 0;
				seq_built = 0;
			end
			CMD_APPEND: begin
				if (seq_len >= MAX_LENGTH) begin
					r.status = STAT_FULL;
				end else begin
					seq_vals[seq_len] = op[15:0];
					seq_len++;
					seq_built = 0;
				end
			end
			CMD_BUILD: seq_built = 1;
			CMD_KTH, CMD_LESS, CMD_AT_MOST, CMD_FREQ: begin
				if (!seq_built) begin
					r.status = STAT_FULL;
				end else if (rs > re || int'(re) > seq_len) begin
					r.status = STAT_BAD_RANGE;
				end else if (c == CMD_KTH) begin
					if (int'(op) >= int'(re) - int'(rs)) begin
						r.status = STAT_BAD_RANK;
					end else begin
						for (int i = rs; i < re; i++)
							sorted.insert(sorted.size(), int'(seq_vals[i]));
						sorted.sort();
						r.answer = 16'(sorted[op]);
					end
				end else if (c == CMD_LESS) begin
					count_below(rs, re, op, cnt, acc);
					r.answer = 16'(cnt);
					r.total = 26'(acc);
				end else if (c == CMD_AT_MOST) begin
					count_below(rs, re, int'(op) + 1, cnt, acc);
					r.answer = 16'(cnt);
					r.total = 26'(acc);
				end else if (op < 17'd65536) begin
					count_below(rs, re, int'(op) + 1, cnt, acc);
					count_below(rs, re, op, cnt2, acc2);
					r.answer = 16'(cnt - cnt2);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// offer one transaction and record its expectation on acceptance
	task automatic send_item(input logic [2:0] c, input logic [10:0] rs,
			input logic [10:0] re, input logic [16:0] op, input bit typed,
			input result_t typed_res);
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, op, re, rs, c};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = predict_result(c, rs, re, op);
		pending_results.insert(pending_results.size(), typed ? typed_res : r);
		items_sent++;
	endtask

	task automatic send_pred(input logic [2:0] c, input int rs, input int re, input int op);
		send_item(c, rs[10:0], re[10:0], op[16:0], 0, '0);
	endtask

	// pick a query aimed at the stored contents
	task automatic send_query();
		int      c, rs, re, op;
		c = ($urandom_range(99) < 3) ? CMD_RSVD : $urandom_range(CMD_KTH, CMD_FREQ);
		if ($urandom_range(99) < 10) begin
			rs = $urandom_range(0, 2047);
			re = $urandom_range(0, 2047);
		end else begin
			rs = $urandom_range(0, seq_len);
			re = $urandom_range(rs, seq_len);
		end
		case ($urandom_range(5))
			0: op = $urandom_range(0, 131071);
			1: op = $urandom_range(0, 3) == 0 ? 0 : 65535 + $urandom_range(0, 2);
			2: op = (c == CMD_KTH) ? $urandom_range(0, 131071) : $urandom_range(0, 16);
			default: begin
				if (c == CMD_KTH)
					op = (re > rs && re - rs <= 2047) ? $urandom_range(0, re - rs) : 0;
				else if (seq_len > 0)
					op = seq_vals[$urandom_range(0, seq_len - 1)] + $urandom_range(0, 2) - 1;
				else
					op = $urandom_range(0, 65535);
				if (op < 0) op = 0;
			end
		endcase
		send_pred(c[2:0], rs, re, op);
	endtask

	task automatic run_session(input int n, input bit wide_vals);
		int v;
		send_pred(CMD_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047),
			$urandom_range(0, 131071));
		for (int i = 0; i < n; i++) begin
			v = wide_vals ? $urandom_range(0, 131071) : $urandom_range(0, 15);
			send_pred(CMD_APPEND, $urandom_range(0, 2047), $urandom_range(0, 2047), v);
		end
		if ($urandom_range(99) < 95) send_pred(CMD_BUILD, 0, 0, 0);
		repeat ($urandom_range(10, 20)) begin
			if ($urandom_range(99) < 3)
				send_pred(CMD_APPEND, 0, 0, $urandom_range(0, 131071));
			else
				send_query();
		end
	endtask

	// result side: stall, long hold-off, compare with oldest expectation
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen == 300) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, m_tdata);
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, m_tdata[1:0]);
				end
				if (m_tdata[17:2] !== want.answer) begin
					errors++;
					$display("%0t: answer expected %0d actual %0d", $time,
						want.answer, m_tdata[17:2]);
				end
				if (m_tdata[43:18] !== want.total) begin
					errors++;
					$display("%0t: total expected %0d actual %0d", $time,
						want.total, m_tdata[43:18]);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	row_t directed[] = '{
		'{CMD_KTH,      0, 0, 0,      1, '{STAT_FULL, 16'd0, 26'd0}},
		'{CMD_CLEAR,    0, 0, 0,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_APPEND,   0, 0, 0,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_APPEND,   0, 0, 65535,  1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_APPEND,   0, 0, 131071, 1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_APPEND,   0, 0, 1,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_APPEND,   0, 0, 7,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_LESS,     0, 5, 9,      1, '{STAT_FULL, 16'd0, 26'd0}},
		'{CMD_BUILD,    0, 0, 0,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_KTH,      0, 5, 0,      0, '0},
		'{CMD_KTH,      0, 5, 4,      0, '0},
		'{CMD_KTH,      0, 5, 5,      1, '{STAT_BAD_RANK, 16'd0, 26'd0}},
		'{CMD_KTH,      3, 3, 0,      1, '{STAT_BAD_RANK, 16'd0, 26'd0}},
		'{CMD_KTH,      4, 2, 0,      1, '{STAT_BAD_RANGE, 16'd0, 26'd0}},
		'{CMD_LESS,     0, 6, 0,      1, '{STAT_BAD_RANGE, 16'd0, 26'd0}},
		'{CMD_LESS,     0, 5, 0,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_LESS,     0, 5, 131071, 0, '0},
		'{CMD_LESS,     1, 4, 65536,  0, '0},
		'{CMD_AT_MOST,  0, 5, 65534,  0, '0},
		'{CMD_AT_MOST,  0, 5, 65535,  0, '0},
		'{CMD_FREQ,     0, 5, 65535,  0, '0},
		'{CMD_FREQ,     0, 5, 65536,  1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_RSVD,     2047, 2047, 131071, 1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_APPEND,   0, 0, 3,      1, '{STAT_OK, 16'd0, 26'd0}},
		'{CMD_AT_MOST,  0, 1, 0,      1, '{STAT_FULL, 16'd0, 26'd0}}
	};

	initial begin
		int session;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].cmd, directed[i].rs, directed[i].re, directed[i].op,
				directed[i].typed, directed[i].res);

		// random sessions, idling pattern rotating per session
		session = 0;
		while (items_sent < 1150 || session < 6) begin
			case (session % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			if (session == 5)
				run_session(MAX_LENGTH + 3, 1);
			else if (session == 4)
				run_session(0, 0);
			else
				run_session($urandom_range(1, 8), $urandom_range(0, 1));
			session++;
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Ran %0d transactions in %0d sessions, incl. a full sequence and a long",
			items_sent, session);
		$display("output hold-off; %0d results checked, %0d mismatches.", results_seen, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
